>>> src/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types, constants and helpers for the life generation step block.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

    // Grid geometry
    localparam int MAX_GRID   = 64;
    localparam int MIN_GRID   = 3;
    localparam int ROW_W      = 64;
    localparam int ADDR_W     = 6;
    localparam int SIZE_W     = 7;
    localparam int CNT_W      = 7;

    // Sweep lengths: a row sweep runs on past the last row
    localparam int LAST_SWEEP = MAX_GRID + 1;
    localparam int LAST_CLEAR = MAX_GRID - 1;

    localparam logic [SIZE_W-1:0] GRID_RESET = SIZE_W'(MAX_GRID);

    // Request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_STEP  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PASS1,
        ST_PASS2
    } lgs_state_t;

    // Control from the sequencer to the datapath
    typedef struct packed {
        logic              in_ready;
        logic              clear_we;
        logic              p1;
        logic              p2;
        logic              rd_wait;
        logic [CNT_W-1:0]  cnt;
    } lgs_ctrl_t;

    // Grid size clamped to the supported range
    function automatic logic [SIZE_W-1:0] lgs_active_size(input logic [SIZE_W-1:0] gs);
        logic [SIZE_W-1:0] s;
        s = gs;
        if (s < SIZE_W'(MIN_GRID))
        begin
            s = SIZE_W'(MIN_GRID);
        end
        if (s > SIZE_W'(MAX_GRID))
        begin
            s = SIZE_W'(MAX_GRID);
        end
        return s;
    endfunction

    // One bit per active column
    function automatic logic [ROW_W-1:0] lgs_col_mask(input logic [SIZE_W-1:0] n);
        logic [ROW_W-1:0] m;
        for (int x = 0; x < ROW_W; x++)
        begin
            m[x] = (SIZE_W'(x) < n);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> src/lgs_row_unit.sv
// ----------------------------------------------------------------------------
// lgs_row_unit
// Shared row unit: B3/S23 next state for one row from a three-row window,
// born/died masks, and the sacrifice mask from a window of born rows.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_row_unit
    import lgs_pkg::*;
(
    input  wire logic [ROW_W-1:0] win_up,
    input  wire logic [ROW_W-1:0] win_mid,
    input  wire logic [ROW_W-1:0] win_dn,
    input  wire logic [ROW_W-1:0] died_in,
    input  wire logic [ROW_W-1:0] col_mask,
    input  wire logic             row_active,
    output logic      [ROW_W-1:0] next_row,
    output logic      [ROW_W-1:0] born_row,
    output logic      [ROW_W-1:0] died_row,
    output logic      [ROW_W-1:0] sac_row
);

    logic [ROW_W-1:0] up_l, up_r, mid_l, mid_r, dn_l, dn_r;
    logic [3:0]       nbr_cnt [ROW_W];
    logic [ROW_W-1:0] rule_hit;
    logic [ROW_W-1:0] any_row;
    logic [ROW_W-1:0] near_row;

    // Neighbor columns: bit x of *_l is column x-1, of *_r is column x+1
    assign up_l  = win_up << 1;
    assign up_r  = win_up >> 1;
    assign mid_l = win_mid << 1;
    assign mid_r = win_mid >> 1;
    assign dn_l  = win_dn << 1;
    assign dn_r  = win_dn >> 1;

    // Per-column neighbor count and rule
    always_comb
    begin
        for (int x = 0; x < ROW_W; x++)
        begin
            nbr_cnt[x] = {3'b000, up_l[x]} + {3'b000, win_up[x]} + {3'b000, up_r[x]}
                       + {3'b000, mid_l[x]} + {3'b000, mid_r[x]}
                       + {3'b000, dn_l[x]} + {3'b000, win_dn[x]} + {3'b000, dn_r[x]};
            rule_hit[x] = (nbr_cnt[x] == 4'd3) || ((nbr_cnt[x] == 4'd2) && win_mid[x]);
        end
    end

    assign next_row = rule_hit & col_mask & {ROW_W{row_active}};
    assign born_row = next_row & ~win_mid;
    assign died_row = win_mid & ~next_row;

    // Sacrifice: died cells with a born cell anywhere around them
    assign any_row  = win_up | win_mid | win_dn;
    assign near_row = ((any_row << 1) | (any_row >> 1) | win_up | win_dn) & col_mask;
    assign sac_row  = died_in & near_row;

endmodule

`default_nettype wire

>>> src/lgs_seq.sv
// ----------------------------------------------------------------------------
// lgs_seq
// Sequencer: clearing pass after reset, request dispatch, and the two row
// sweeps of a generation step.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_seq
    import lgs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] req_type,
    input  wire logic       out_free,
    output lgs_ctrl_t       ctrl
);

    lgs_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             in_fire;

    assign in_fire = in_valid && (state_reg == ST_IDLE);

    // State and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(LAST_CLEAR))
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
            end
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_fire && (req_type == REQ_STEP))
                begin
                    state_next = ST_PASS1;
                end
                else if (in_fire && (req_type == REQ_READ))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PASS1:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(LAST_SWEEP))
                begin
                    state_next = ST_PASS2;
                    cnt_next   = '0;
                end
            end
            ST_PASS2:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(LAST_SWEEP))
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        ctrl          = '0;
        ctrl.cnt      = cnt_reg;
        unique case (state_reg)
            ST_CLEAR: ctrl.clear_we = 1'b1;
            ST_IDLE:  ctrl.in_ready = 1'b1;
            ST_READ:  ctrl.rd_wait  = 1'b1;
            ST_PASS1: ctrl.p1       = 1'b1;
            ST_PASS2: ctrl.p2       = 1'b1;
            default:  ctrl.in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> src/life_generation_step_top.sv
// ----------------------------------------------------------------------------
// life_generation_step_top
// Game of life grid (B3/S23, no wraparound) with row write, row read and
// generation step requests.
// ----------------------------------------------------------------------------
// Timing: after reset a clearing pass zeroes the four row memories, with
// in_ready low (grid size writes are taken throughout). A row read has two
// steps: the registered memory read, then the load of the output word once
// the output register is free; the word then waits in its own register while
// the next word is accepted. A generation step is the accepting cycle, then
// two sweeps through one shared row unit, one row per cycle, set by the single
// read port of each row memory (first sweep: next state, born and died rows;
// second sweep: sacrifice rows from the born rows).
`default_nettype none

module life_generation_step_top
    import lgs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // grid size register
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [SIZE_W-1:0] cfg_grid_size,
    // requests
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        req_type,
    input  wire logic [ADDR_W-1:0] row_index,
    input  wire logic [ROW_W-1:0]  row_cells,
    // row read results
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [ROW_W-1:0]  alive_cells,
    output logic      [ROW_W-1:0]  born_cells,
    output logic      [ROW_W-1:0]  died_cells,
    output logic      [ROW_W-1:0]  sacrificed_cells
);

    // accepting cycle plus two sweeps
    localparam int STEP_CYCLES = 2 * (LAST_SWEEP + 1) + 1;

    lgs_ctrl_t         ctrl;
    logic [SIZE_W-1:0] grid_size_reg;
    logic [SIZE_W-1:0] act_n;
    logic [ROW_W-1:0]  col_mask;

    logic              in_fire, req_write, req_read, row_in_range;
    logic [ADDR_W-1:0] sweep_adr, wr_adr, dn_adr;
    logic [CNT_W-1:0]  wr_cnt, dn_cnt;
    logic              rd_sweep, wr_sweep, dn_ok, died_sweep, row_active;

    logic [ROW_W-1:0]  live_mem [MAX_GRID];
    logic [ROW_W-1:0]  born_mem [MAX_GRID];
    logic [ROW_W-1:0]  died_mem [MAX_GRID];
    logic [ROW_W-1:0]  sac_mem  [MAX_GRID];

    logic [ROW_W-1:0]  live_rd_reg, born_rd_reg, died_rd_reg, sac_rd_reg;
    logic              live_re, born_re, died_re, sac_re;
    logic [ADDR_W-1:0] live_raddr, born_raddr, died_raddr;
    logic              live_we, mask_we, sac_we;
    logic [ADDR_W-1:0] live_waddr, mask_waddr;
    logic [ROW_W-1:0]  live_wdata, born_wdata, died_wdata, sac_wdata;

    logic [ROW_W-1:0]  win_up_reg, win_mid_reg, win_dn, sweep_rd;
    logic [ROW_W-1:0]  next_row, born_row, died_row, sac_row;

    logic              rd_zero_reg;
    logic              out_valid_reg, out_free, out_load;
    logic [ROW_W-1:0]  alive_reg, born_reg, died_reg, sac_reg;

    // Grid size register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GRID_RESET;
        end
        else if (cfg_valid)
        begin
            grid_size_reg <= cfg_grid_size;
        end
    end

    assign act_n    = lgs_active_size(grid_size_reg);
    assign col_mask = lgs_col_mask(act_n);

    // Sequencer
    lgs_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    assign in_ready     = ctrl.in_ready;
    assign in_fire      = in_valid && ctrl.in_ready;
    assign req_write    = in_fire && (req_type == REQ_WRITE);
    assign req_read     = in_fire && (req_type == REQ_READ);
    assign row_in_range = ({1'b0, row_index} < act_n);

    // Sweep addressing: read row cnt, neighbor below is row cnt-1,
    // row being produced is cnt-2
    assign sweep_adr  = ctrl.cnt[ADDR_W-1:0];
    assign rd_sweep   = (ctrl.cnt < CNT_W'(MAX_GRID));
    assign wr_cnt     = ctrl.cnt - CNT_W'(2);
    assign wr_sweep   = (ctrl.cnt >= CNT_W'(2));
    assign wr_adr     = wr_cnt[ADDR_W-1:0];
    assign row_active = (wr_cnt < act_n);
    assign dn_cnt     = ctrl.cnt - CNT_W'(1);
    assign dn_adr     = dn_cnt[ADDR_W-1:0];
    assign dn_ok      = (ctrl.cnt != '0) && (dn_cnt < act_n);
    assign died_sweep = (ctrl.cnt != '0) && (ctrl.cnt <= CNT_W'(MAX_GRID));

    // Read ports
    assign live_re    = req_read || (ctrl.p1 && rd_sweep);
    assign live_raddr = ctrl.p1 ? sweep_adr : row_index;
    assign born_re    = req_read || (ctrl.p2 && rd_sweep);
    assign born_raddr = ctrl.p2 ? sweep_adr : row_index;
    assign died_re    = req_read || (ctrl.p2 && died_sweep);
    assign died_raddr = ctrl.p2 ? dn_adr : row_index;
    assign sac_re     = req_read;

    // Write ports
    assign live_we    = ctrl.clear_we || (req_write && row_in_range) || (ctrl.p1 && wr_sweep);
    assign live_waddr = ctrl.clear_we ? sweep_adr : (ctrl.p1 ? wr_adr : row_index);
    assign live_wdata = ctrl.clear_we ? '0 : (ctrl.p1 ? next_row : (row_cells & col_mask));
    assign mask_we    = ctrl.clear_we || (ctrl.p1 && wr_sweep);
    assign mask_waddr = ctrl.clear_we ? sweep_adr : wr_adr;
    assign born_wdata = ctrl.clear_we ? '0 : born_row;
    assign died_wdata = ctrl.clear_we ? '0 : died_row;
    assign sac_we     = ctrl.clear_we || (ctrl.p2 && wr_sweep);
    assign sac_wdata  = ctrl.clear_we ? '0 : sac_row;

    // Live row memory
    always_ff @(posedge clk)
    begin
        if (live_we)
        begin
            live_mem[live_waddr] <= live_wdata;
        end
        if (live_re)
        begin
            live_rd_reg <= live_mem[live_raddr];
        end
    end

    // Born and died row memories
    always_ff @(posedge clk)
    begin
        if (mask_we)
        begin
            born_mem[mask_waddr] <= born_wdata;
            died_mem[mask_waddr] <= died_wdata;
        end
        if (born_re)
        begin
            born_rd_reg <= born_mem[born_raddr];
        end
        if (died_re)
        begin
            died_rd_reg <= died_mem[died_raddr];
        end
    end

    // Sacrifice row memory
    always_ff @(posedge clk)
    begin
        if (sac_we)
        begin
            sac_mem[mask_waddr] <= sac_wdata;
        end
        if (sac_re)
        begin
            sac_rd_reg <= sac_mem[row_index];
        end
    end

    // Three-row window; rows outside the active area enter as zero
    assign sweep_rd = ctrl.p1 ? live_rd_reg : born_rd_reg;
    assign win_dn   = dn_ok ? (sweep_rd & col_mask) : '0;

    always_ff @(posedge clk)
    begin
        if (ctrl.p1 || ctrl.p2)
        begin
            if (ctrl.cnt == '0)
            begin
                win_up_reg  <= '0;
                win_mid_reg <= '0;
            end
            else
            begin
                win_up_reg  <= win_mid_reg;
                win_mid_reg <= win_dn;
            end
        end
    end

    // Shared row unit
    lgs_row_unit u_row (
        .win_up     (win_up_reg),
        .win_mid    (win_mid_reg),
        .win_dn     (win_dn),
        .died_in    (died_rd_reg),
        .col_mask   (col_mask),
        .row_active (row_active),
        .next_row   (next_row),
        .born_row   (born_row),
        .died_row   (died_row),
        .sac_row    (sac_row)
    );

    // Out-of-range read flag
    always_ff @(posedge clk)
    begin
        if (req_read)
        begin
            rd_zero_reg <= !row_in_range;
        end
    end

    // Output word register
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = ctrl.rd_wait && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            alive_reg <= rd_zero_reg ? '0 : (live_rd_reg & col_mask);
            born_reg  <= rd_zero_reg ? '0 : (born_rd_reg & col_mask);
            died_reg  <= rd_zero_reg ? '0 : (died_rd_reg & col_mask);
            sac_reg   <= rd_zero_reg ? '0 : (sac_rd_reg & col_mask);
        end
    end

    assign out_valid        = out_valid_reg;
    assign alive_cells      = alive_reg;
    assign born_cells       = born_reg;
    assign died_cells       = died_reg;
    assign sacrificed_cells = sac_reg;

`ifndef SYNTHESIS
    // Sequencer phases never overlap
    a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.in_ready, ctrl.clear_we, ctrl.p1, ctrl.p2, ctrl.rd_wait}))
        else $error("sequencer phases overlap");

    // Sweep counter stays within the sweep
    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.p1 || ctrl.p2) |-> (ctrl.cnt <= CNT_W'(LAST_SWEEP)))
        else $error("sweep counter overran");

    // Accepted read moves to the output wait phase
    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (req_type == REQ_READ)) |=> ctrl.rd_wait)
        else $error("read not followed by output wait");

    // A step returns to idle after two full sweeps
    a_step_len: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (req_type == REQ_STEP)) |-> ##STEP_CYCLES in_ready)
        else $error("step length wrong");

    // Output words only come from reads
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctrl.rd_wait))
        else $error("output word without a read");
`endif

endmodule

`default_nettype wire

>>> sim/tb_life_generation_step_top.sv
// ----------------------------------------------------------------------------
// tb_life_generation_step_top
// Self-checking bench for the life grid block. A behavioral copy of the grid
// (live cells plus born, died and sacrificed masks) tracks every accepted
// request. Each row word read back is compared field by field with the oldest
// pending read. Directed tests cover the edge rows, the edge columns, the
// unused request code and size clamping. Random pattern runs follow, under
// several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_life_generation_step_top
    import lgs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [ROW_W-1:0] row_t;

    // One row word as returned by a read
    typedef struct packed {
        row_t alive;
        row_t born;
        row_t died;
        row_t sacrificed;
    } row_report_t;

    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 150;        // outlasts a generation step
    localparam int         RANDOM_GOAL   = 400;        // requests per idling phase
    localparam int         TIMEOUT_NS    = 20_000_000;
    localparam int         MAX_PRINTED   = 40;

    // DUT ports
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [SIZE_W-1:0]   cfg_grid_size = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          req_type = REQ_WRITE;
    logic [ADDR_W-1:0]   row_index = '0;
    row_t                row_cells = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    row_t                alive_cells;
    row_t                born_cells;
    row_t                died_cells;
    row_t                sacrificed_cells;

    // Grid copy kept by the bench
    row_t                grid_live       [MAX_GRID];
    row_t                grid_born       [MAX_GRID];
    row_t                grid_died       [MAX_GRID];
    row_t                grid_sacrificed [MAX_GRID];
    logic [SIZE_W-1:0]   size_setting;

    row_report_t         pending_reads [$];
    row_report_t         oldest_read;

    int                  sender_idle_pct    = 0;
    int                  receiver_stall_pct = 0;
    int                  mismatch_count     = 0;
    int                  requests_applied   = 0;
    int                  steps_applied      = 0;
    int                  words_checked      = 0;
    int                  size_writes        = 0;

    life_generation_step_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_grid_size    (cfg_grid_size),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .row_index        (row_index),
        .row_cells        (row_cells),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .alive_cells      (alive_cells),
        .born_cells       (born_cells),
        .died_cells       (died_cells),
        .sacrificed_cells (sacrificed_cells)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Grid model
    // ------------------------------------------------------------------

    // Size register clamped to 3..MAX_GRID
    function automatic int active_rows();
        int s;
        s = int'(size_setting);
        if (s < MIN_GRID)
        begin
            s = MIN_GRID;
        end
        if (s > MAX_GRID)
        begin
            s = MAX_GRID;
        end
        return s;
    endfunction

    function automatic row_t column_mask(input int n);
        return (n >= ROW_W) ? '1 : ((row_t'(1) << n) - row_t'(1));
    endfunction

    // One B3/S23 generation, no wraparound, plus the three masks
    function automatic void advance_generation();
        row_t live_pad [MAX_GRID+2];
        row_t born_pad [MAX_GRID+2];
        row_t next_live [MAX_GRID];
        row_t m;
        row_t up;
        row_t mid;
        row_t dn;
        row_t around;
        int   n;
        int   cnt;
        int   xx;
        n = active_rows();
        m = column_mask(n);
        for (int y = 0; y < MAX_GRID + 2; y++)
        begin
            live_pad[y] = '0;
            born_pad[y] = '0;
        end
        // padded copy: index y+1 holds row y, rows outside the size are dead
        for (int y = 0; y < n; y++)
        begin
            live_pad[y+1] = grid_live[y] & m;
        end
        for (int y = 0; y < MAX_GRID; y++)
        begin
            next_live[y] = '0;
            up  = live_pad[y];
            mid = live_pad[y+1];
            dn  = live_pad[y+2];
            if (y < n)
            begin
                for (int x = 0; x < n; x++)
                begin
                    cnt = 0;
                    for (int dx = -1; dx <= 1; dx++)
                    begin
                        xx = x + dx;
                        if (xx >= 0 && xx < ROW_W)
                        begin
                            cnt += up[xx] + dn[xx];
                            if (dx != 0)
                            begin
                                cnt += mid[xx];
                            end
                        end
                    end
                    if (cnt == 3 || (cnt == 2 && mid[x]))
                    begin
                        next_live[y][x] = 1'b1;
                    end
                end
            end
        end
        for (int y = 0; y < MAX_GRID; y++)
        begin
            grid_born[y]  = next_live[y] & ~live_pad[y+1] & m;
            grid_died[y]  = live_pad[y+1] & ~next_live[y] & m;
            born_pad[y+1] = (y < n) ? grid_born[y] : '0;
        end
        // a death counts as a sacrifice when any of its 8 neighbors was born
        for (int y = 0; y < MAX_GRID; y++)
        begin
            around = born_pad[y] | born_pad[y+1] | born_pad[y+2];
            grid_sacrificed[y] = grid_died[y]
                & ((around << 1) | (around >> 1) | born_pad[y] | born_pad[y+2]) & m;
        end
        for (int y = 0; y < MAX_GRID; y++)
        begin
            grid_live[y] = next_live[y];
        end
    endfunction

    // Update the model for one accepted request word
    function automatic void apply_request(input logic [1:0] kind,
                                          input logic [ADDR_W-1:0] row,
                                          input row_t cells);
        int          n;
        row_t        m;
        row_report_t rr;
        n = active_rows();
        m = column_mask(n);
        case (kind)
            REQ_WRITE:
            begin
                if (row < n)
                begin
                    grid_live[row] = cells & m;
                    requests_applied++;
                end
            end
            REQ_STEP:
            begin
                advance_generation();
                requests_applied++;
                steps_applied++;
            end
            REQ_READ:
            begin
                rr = '0;
                if (row < n)
                begin
                    rr.alive      = grid_live[row] & m;
                    rr.born       = grid_born[row] & m;
                    rr.died       = grid_died[row] & m;
                    rr.sacrificed = grid_sacrificed[row] & m;
                end
                // queue the expected word behind older reads
                pending_reads = {pending_reads, rr};
                requests_applied++;
            end
            default:
            begin
                // unused code: no effect
            end
        endcase
    endfunction

    function automatic row_t random_cells(input int thin);
        row_t w;
        w = {$urandom, $urandom};
        repeat (thin)
        begin
            w &= {$urandom, $urandom};
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one request word; valid stays high on return for back-to-back
    task automatic send_req(input logic [1:0] kind, input logic [ADDR_W-1:0] row,
                            input row_t cells);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= kind;
        row_index <= row;
        row_cells <= cells;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        apply_request(kind, row, cells);
    endtask

    // Drop valid, wait for all reads to return, then let a step finish
    task automatic settle(input int cycles);
        in_valid <= 1'b0;
        while (pending_reads.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (cycles)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_grid_size(input logic [SIZE_W-1:0] value);
        settle(SETTLE_CYCLES);
        cfg_valid     <= 1'b1;
        cfg_grid_size <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid    <= 1'b0;
        size_setting  = value;
        size_writes++;
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
        begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string field, input row_t got, input row_t want);
        if (got !== want)
        begin
            flag_mismatch($sformatf("word %0d %s: got %h, want %h",
                                    words_checked, field, got, want));
        end
    endtask

    // Accept row words, compare with the oldest pending read, randomize ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reads.size() == 0)
            begin
                flag_mismatch("row word returned with no read pending");
            end
            else
            begin
                oldest_read = pending_reads.pop_front();
                check_field("alive", alive_cells, oldest_read.alive);
                check_field("born", born_cells, oldest_read.born);
                check_field("died", died_cells, oldest_read.died);
                check_field("sacrificed", sacrificed_cells, oldest_read.sacrificed);
                words_checked++;
            end
        end
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Edge rows, full and empty words, unused request code
    task automatic test_row_access();
        send_req(REQ_READ, 6'd5, '0);
        send_req(REQ_WRITE, 6'd0, '1);
        send_req(REQ_WRITE, 6'd63, '1);
        send_req(REQ_WRITE, 6'd40, random_cells(0));
        send_req(REQ_READ, 6'd40, '0);
        send_req(REQ_UNUSED, 6'd0, '0);    // must leave row 0 untouched
        send_req(REQ_READ, 6'd0, '0);
    endtask

    // Blinker at the left edge, full edge rows dying at the corners
    task automatic test_generation_step();
        send_req(REQ_WRITE, 6'd31, 64'h7);
        send_req(REQ_STEP, '0, '0);
        send_req(REQ_READ, 6'd0, '0);
        send_req(REQ_READ, 6'd1, '0);
        send_req(REQ_READ, 6'd31, '0);
        send_req(REQ_READ, 6'd32, '0);
        send_req(REQ_READ, 6'd63, '0);
        // a write changes live cells only, masks stay
        send_req(REQ_WRITE, 6'd31, '0);
        send_req(REQ_READ, 6'd31, '0);
    endtask

    // Smallest grid, clamping at both ends, shrink then regrow
    task automatic test_size_limits();
        write_grid_size(7'd3);
        send_req(REQ_WRITE, 6'd2, '1);     // columns past the size dropped
        send_req(REQ_WRITE, 6'd3, '1);     // row past the size ignored
        send_req(REQ_READ, 6'd2, '0);
        send_req(REQ_READ, 6'd3, '0);
        write_grid_size(7'd127);           // acts as 64; old rows reappear
        send_req(REQ_READ, 6'd63, '0);
        write_grid_size(7'd0);             // acts as 3
        send_req(REQ_STEP, '0, '0);
        send_req(REQ_READ, 6'd1, '0);
        send_req(REQ_READ, 6'd2, '0);
        write_grid_size(GRID_RESET);       // rows cleared by the small step
        send_req(REQ_READ, 6'd63, '0);
    endtask

    // Random patterns: load a grid, evolve it with reads between steps,
    // sprinkle a few random request words
    task automatic test_random_evolution(input int send_pct, input int recv_pct);
        int                pick;
        int                n;
        int                thin;
        int                goal;
        logic [SIZE_W-1:0] size_value;
        settle(SETTLE_CYCLES);
        sender_idle_pct    = send_pct;
        receiver_stall_pct = recv_pct;
        goal = requests_applied + RANDOM_GOAL;
        while (requests_applied < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                size_value = SIZE_W'($urandom_range(3, 12));
            end
            else if (pick < 85)
            begin
                size_value = SIZE_W'($urandom_range(13, 64));
            end
            else if (pick < 93)
            begin
                size_value = SIZE_W'($urandom_range(0, 2));
            end
            else
            begin
                size_value = SIZE_W'($urandom_range(65, 127));
            end
            write_grid_size(size_value);
            n    = active_rows();
            thin = $urandom_range(0, 2);
            for (int r = 0; r < n; r++)
            begin
                send_req(REQ_WRITE, ADDR_W'(r), random_cells(thin));
            end
            repeat ($urandom_range(1, 4))
            begin
                send_req(REQ_STEP, ADDR_W'($urandom_range(0, 63)), random_cells(0));
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        send_req(REQ_READ, ADDR_W'($urandom_range(0, 63)), random_cells(0));
                    end
                    else
                    begin
                        send_req(REQ_READ, ADDR_W'($urandom_range(0, n - 1)),
                                 random_cells(0));
                    end
                end
            end
            // noise words of any kind
            repeat ($urandom_range(0, 3))
            begin
                send_req(2'($urandom_range(0, 3)), ADDR_W'($urandom_range(0, 63)),
                         random_cells($urandom_range(0, 1)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int y = 0; y < MAX_GRID; y++)
        begin
            grid_live[y]       = '0;
            grid_born[y]       = '0;
            grid_died[y]       = '0;
            grid_sacrificed[y] = '0;
        end
        size_setting = GRID_RESET;

        repeat (3)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;

        test_row_access();
        test_generation_step();
        test_size_limits();
        test_random_evolution(0, 0);
        test_random_evolution(87, 0);
        test_random_evolution(0, 87);
        test_random_evolution(10, 10);

        settle(SETTLE_CYCLES);
        $display("Run covered %0d effective requests, %0d generation steps, %0d row words",
                 requests_applied, steps_applied, words_checked);
        $display("checked, %0d grid size writes across four idling mixes", size_writes);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("ERROR: run timed out");
        $display("Mismatches found");
        $finish;
    end

endmodule
